### src/ptss_pkg.sv
// ----------------------------------------------------------------------------
// ptss_pkg - periodic task slot scheduler package
// Sizes, command and status codes, slot entry layout and small helpers shared
// by the scheduler, its channel interfaces and its checker.
// ----------------------------------------------------------------------------
package ptss_pkg;

	// table geometry
	localparam int SLOT_COUNT    = 8;
	localparam int TIME_WIDTH    = 16;
	localparam int PENDING_WIDTH = 8;
	localparam int MAX_RESULTS   = 8;

	localparam int IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
	localparam int NRES_W = $clog2(MAX_RESULTS + 1);

	// fixed field widths of the channels
	localparam int CMD_W      = 2;
	localparam int TIME_IN_W  = 16;
	localparam int SLOT_IN_W  = 8;
	localparam int STATUS_W   = 2;
	localparam int SLOT_W     = 4;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK     = 2'd0,
		CMD_ADD      = 2'd1,
		CMD_DELETE   = 2'd2,
		CMD_DISPATCH = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	// one slot entry as held in the slot memory
	typedef struct packed {
		logic [TIME_WIDTH-1:0]    delay;
		logic [TIME_WIDTH-1:0]    period;
		logic [PENDING_WIDTH-1:0] pending;
	} entry_t;

	// one result as held in the output register
	typedef struct packed {
		status_t           status;
		logic [SLOT_W-1:0] slot;
		logic              run_task;
		logic              last;
	} result_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] idx;
	} pick_t;

	localparam logic [PENDING_WIDTH-1:0] PEND_MAX = '1;

	// lowest set bit of a slot mask
	function automatic pick_t lowest_set(input logic [SLOT_COUNT-1:0] mask);
		pick_t p;
		p = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (mask[i]) begin
				p.found = 1'b1;
				p.idx   = IDX_W'(i);
			end
		end
		return p;
	endfunction

	// slot number onto the 4-bit result field
	function automatic logic [SLOT_W-1:0] slot_field(input logic [CNT_W-1:0] v);
		logic [CNT_W+SLOT_W-1:0] ext;
		ext = {{SLOT_W{1'b0}}, v};
		return ext[SLOT_W-1:0];
	endfunction

	// request time field onto the internal time width
	function automatic logic [TIME_WIDTH-1:0] time_field(input logic [TIME_IN_W-1:0] v);
		logic [TIME_IN_W+TIME_WIDTH-1:0] ext;
		ext = {{TIME_WIDTH{1'b0}}, v};
		return ext[TIME_WIDTH-1:0];
	endfunction

endpackage

### src/ptss_req_if.sv
// ----------------------------------------------------------------------------
// ptss_req_if - scheduler request channel
// Valid/ready channel carrying one command with its operands.
// ----------------------------------------------------------------------------
interface ptss_req_if import ptss_pkg::*; ();

	logic                 valid;
	logic                 ready;
	logic [CMD_W-1:0]     command;
	logic [TIME_IN_W-1:0] first_delay;
	logic [TIME_IN_W-1:0] repeat_period;
	logic [SLOT_IN_W-1:0] slot_index;

	modport source (
		output valid, command, first_delay, repeat_period, slot_index,
		input  ready
	);

	modport sink (
		input  valid, command, first_delay, repeat_period, slot_index,
		output ready
	);

endinterface

### src/ptss_rsp_if.sv
// ----------------------------------------------------------------------------
// ptss_rsp_if - scheduler result channel
// Valid/ready channel carrying one result of a request.
// ----------------------------------------------------------------------------
interface ptss_rsp_if import ptss_pkg::*; ();

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0]   slot;
	logic                run_task;
	logic                last;

	modport source (
		output valid, status, slot, run_task, last,
		input  ready
	);

	modport sink (
		input  valid, status, slot, run_task, last,
		output ready
	);

endinterface

### src/periodic_task_slot_scheduler_unit.sv
// ----------------------------------------------------------------------------
// periodic_task_slot_scheduler_unit - time-triggered task slot scheduler
// Slot table with add, delete, tick and dispatch requests over valid/ready.
// ----------------------------------------------------------------------------
// Delay, period and pending count of every slot live in one synchronous slot
// memory with a single registered read port; valid and pending-nonzero
// marks are flip-flops, so reset needs no clearing pass. One request is
// worked at a time. A tick walks the memory one slot a cycle, reading the
// next slot while the previous one is written back. A dispatch reads each
// pending slot, then writes it back and delivers its result. Each request
// gives its results in order, the final one flagged last; a result waits in
// the output register while the next request is taken.
// ----------------------------------------------------------------------------
module periodic_task_slot_scheduler_unit import ptss_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	ptss_req_if.sink   req,
	ptss_rsp_if.source rsp
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_TICK,
		S_ADD,
		S_DELETE,
		S_DISPATCH
	} state_t;

	state_t                  state_q;
	logic [SLOT_COUNT-1:0]   valid_q;
	logic [SLOT_COUNT-1:0]   nz_q;
	logic [SLOT_COUNT-1:0]   rem_q;
	logic [NRES_W-1:0]       res_cnt_q;
	logic [CNT_W-1:0]        walk_cnt_q;
	logic                    rd_vld_s1;
	logic [IDX_W-1:0]        rd_idx_s1;
	entry_t                  rd_data_s1;

	logic [TIME_IN_W-1:0]    first_delay_q;
	logic [TIME_IN_W-1:0]    repeat_period_q;
	logic [SLOT_IN_W-1:0]    slot_index_q;

	logic                    out_valid_q;
	result_t                 out_q;

	entry_t                  slot_mem [SLOT_COUNT];

	logic                    accept;
	logic                    out_free;
	logic                    out_load;
	pick_t                   free_pick;
	pick_t                   cand_pick;
	entry_t                  tick_entry;
	logic [PENDING_WIDTH-1:0] pend_dec;
	logic [SLOT_COUNT-1:0]   sel_s1;
	logic [SLOT_COUNT-1:0]   rem_after;
	logic                    disp_last;
	logic                    walk_busy;

	logic                    mem_we;
	logic [IDX_W-1:0]        mem_waddr;
	entry_t                  mem_wdata;
	logic                    mem_re;
	logic [IDX_W-1:0]        mem_raddr;

	// handshakes
	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;

	assign rsp.valid    = out_valid_q;
	assign rsp.status   = out_q.status;
	assign rsp.slot     = out_q.slot;
	assign rsp.run_task = out_q.run_task;
	assign rsp.last     = out_q.last;

	// slot selection
	assign free_pick = lowest_set(~valid_q);
	assign cand_pick = lowest_set(rem_q);
	assign walk_busy = (walk_cnt_q < CNT_W'(SLOT_COUNT));

	// tick update of the slot just read
	always_comb begin
		tick_entry = rd_data_s1;
		if (rd_data_s1.delay == '0) begin
			if (rd_data_s1.pending != PEND_MAX) begin
				tick_entry.pending = rd_data_s1.pending + 1'b1;
			end
			if (rd_data_s1.period != '0) begin
				tick_entry.delay = rd_data_s1.period - 1'b1;
			end
		end else begin
			tick_entry.delay = rd_data_s1.delay - 1'b1;
		end
	end

	// dispatch update of the slot just read
	assign pend_dec  = rd_data_s1.pending - 1'b1;
	assign sel_s1    = {{(SLOT_COUNT-1){1'b0}}, 1'b1} << rd_idx_s1;
	assign rem_after = rem_q & ~sel_s1;
	assign disp_last = (rem_after == '0) || (res_cnt_q == NRES_W'(MAX_RESULTS - 1));

	// output register load
	always_comb begin
		case (state_q)
			S_TICK: begin
				out_load = !walk_busy && !rd_vld_s1 && out_free;
			end
			S_ADD, S_DELETE: begin
				out_load = out_free;
			end
			S_DISPATCH: begin
				out_load = out_free && (rd_vld_s1 || rem_q == '0);
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	// slot memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = rd_idx_s1;
		mem_wdata = tick_entry;
		mem_re    = 1'b0;
		mem_raddr = cand_pick.idx;
		case (state_q)
			S_TICK: begin
				if (walk_busy) begin
					mem_re    = 1'b1;
					mem_raddr = walk_cnt_q[IDX_W-1:0];
				end
				if (rd_vld_s1 && valid_q[rd_idx_s1]) begin
					mem_we = 1'b1;
				end
			end
			S_ADD: begin
				if (out_free && free_pick.found) begin
					mem_we    = 1'b1;
					mem_waddr = free_pick.idx;
					mem_wdata = '{delay:   time_field(first_delay_q),
					              period:  time_field(repeat_period_q),
					              pending: '0};
				end
			end
			S_DISPATCH: begin
				if (!rd_vld_s1 && rem_q != '0) begin
					mem_re = 1'b1;
				end
				if (rd_vld_s1 && out_free) begin
					mem_we    = 1'b1;
					mem_wdata = '{delay:   rd_data_s1.delay,
					              period:  rd_data_s1.period,
					              pending: pend_dec};
				end
			end
			default: begin
			end
		endcase
	end

	// slot memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_s1 <= slot_mem[mem_raddr];
		end
	end

	// request operands
	always_ff @(posedge clk) begin
		if (accept) begin
			first_delay_q   <= req.first_delay;
			repeat_period_q <= req.repeat_period;
			slot_index_q    <= req.slot_index;
		end
	end

	// sequencer, slot marks and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			valid_q     <= '0;
			nz_q        <= '0;
			rem_q       <= '0;
			res_cnt_q   <= '0;
			walk_cnt_q  <= '0;
			rd_vld_s1   <= 1'b0;
			rd_idx_s1   <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '{status: ST_OK, slot: '0, run_task: 1'b0, last: 1'b0};
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						rd_vld_s1 <= 1'b0;
						case (cmd_t'(req.command))
							CMD_TICK: begin
								walk_cnt_q <= '0;
								state_q    <= S_TICK;
							end
							CMD_ADD: begin
								state_q <= S_ADD;
							end
							CMD_DELETE: begin
								state_q <= S_DELETE;
							end
							CMD_DISPATCH: begin
								rem_q     <= valid_q & nz_q;
								res_cnt_q <= '0;
								state_q   <= S_DISPATCH;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end

				// walk all slots, write back the one read last cycle
				S_TICK: begin
					rd_vld_s1 <= mem_re;
					rd_idx_s1 <= mem_raddr;
					if (mem_re) begin
						walk_cnt_q <= walk_cnt_q + 1'b1;
					end
					if (mem_we) begin
						nz_q[rd_idx_s1] <= (tick_entry.pending != '0);
					end
					if (!walk_busy && !rd_vld_s1 && out_free) begin
						out_q       <= '{status: ST_OK, slot: '0, run_task: 1'b0,
						                 last: 1'b1};
						state_q     <= S_IDLE;
					end
				end

				// take the lowest free slot
				S_ADD: begin
					if (out_free) begin
						if (free_pick.found) begin
							valid_q[free_pick.idx] <= 1'b1;
							nz_q[free_pick.idx]    <= 1'b0;
							out_q <= '{status: ST_OK,
							           slot: slot_field(CNT_W'(free_pick.idx)),
							           run_task: 1'b0, last: 1'b1};
						end else begin
							out_q <= '{status: ST_FULL,
							           slot: slot_field(CNT_W'(SLOT_COUNT)),
							           run_task: 1'b0, last: 1'b1};
						end
						state_q <= S_IDLE;
					end
				end

				// free the named slot
				S_DELETE: begin
					if (out_free) begin
						if (slot_index_q >= SLOT_IN_W'(SLOT_COUNT)) begin
							out_q <= '{status: ST_RANGE, slot: '0, run_task: 1'b0,
							           last: 1'b1};
						end else begin
							valid_q[slot_index_q[IDX_W-1:0]] <= 1'b0;
							out_q <= '{status: ST_OK, slot: slot_index_q[SLOT_W-1:0],
							           run_task: 1'b0, last: 1'b1};
						end
						state_q <= S_IDLE;
					end
				end

				// read each pending slot, then write back and report it
				S_DISPATCH: begin
					if (!rd_vld_s1) begin
						if (rem_q == '0) begin
							if (out_free) begin
								out_q <= '{status: ST_OK, slot: '0, run_task: 1'b0,
								           last: 1'b1};
								state_q <= S_IDLE;
							end
						end else begin
							rd_vld_s1 <= 1'b1;
							rd_idx_s1 <= cand_pick.idx;
						end
					end else if (out_free) begin
						nz_q[rd_idx_s1] <= (pend_dec != '0);
						if (rd_data_s1.period == '0) begin
							valid_q[rd_idx_s1] <= 1'b0;
						end
						rem_q       <= rem_after;
						res_cnt_q   <= res_cnt_q + 1'b1;
						rd_vld_s1   <= 1'b0;
						out_q <= '{status: ST_OK, slot: slot_field(CNT_W'(rd_idx_s1)),
						           run_task: 1'b1, last: disp_last};
						if (disp_last) begin
							state_q <= S_IDLE;
						end
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### src/ptss_checker.sv
// ----------------------------------------------------------------------------
// ptss_port_checker - port checks for the task slot scheduler
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module ptss_port_checker import ptss_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic [STATUS_W-1:0] rsp_status,
	input logic [SLOT_W-1:0]   rsp_slot,
	input logic                rsp_run_task,
	input logic                rsp_last
);

	// a stalled result holds its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_slot) && $stable(rsp_run_task) && $stable(rsp_last))
		else $error("result changed while stalled");

	// one request at a time: ready drops after each accepted request
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in work");

	// no new request while a dispatch still has results to give
	a_disp_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_last |-> !req_ready)
		else $error("request ready in the middle of a dispatch");

	// an error result is a lone final result naming no task
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != ST_OK |-> rsp_last && !rsp_run_task)
		else $error("error result not final or runs a task");

	// a full table reports the slot count
	a_full_slot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_FULL |-> rsp_slot == slot_field(CNT_W'(SLOT_COUNT)))
		else $error("table full with wrong slot");

endmodule

bind periodic_task_slot_scheduler_unit ptss_port_checker u_ptss_port_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_status   (rsp.status),
	.rsp_slot     (rsp.slot),
	.rsp_run_task (rsp.run_task),
	.rsp_last     (rsp.last)
);
